/* rtl/ostb_pkg.sv */
// Shared types and constants for the one-shot timer bank.
package ostb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W      = 16;
	localparam int IDX_W      = 3;
	localparam int MASK_W     = 8;

	typedef logic [1:0]        op_t;
	typedef logic [AW-1:0]     addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam op_t OP_TICK  = 2'd0;
	localparam op_t OP_START = 2'd1;
	localparam op_t OP_STOP  = 2'd2;
	localparam op_t OP_QUERY = 2'd3;

	localparam addr_t LAST_ADDR = addr_t'(NUM_TIMERS - 1);

	typedef struct packed {
		logic running;
		logic flag;
		cnt_t count;
		cnt_t period;
	} ent_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		cnt_t             period;
	} item_t;

	typedef struct packed {
		logic              flag;
		logic              running;
		logic [MASK_W-1:0] mask;
	} res_t;

	typedef struct packed {
		logic  re;
		addr_t raddr;
		logic  we;
		addr_t waddr;
		ent_t  wdata;
	} mem_req_t;

endpackage

/* rtl/ostb_mem.sv */
// Timer entry memory: one read and one write port, registered read, per-entry valid bits.
module ostb_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  ostb_pkg::mem_req_t req,
	output ostb_pkg::ent_t    rd_ent
);
	import ostb_pkg::*;

	ent_t                  mem_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] vld_q;
	ent_t                  rdata_q;
	logic                  rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.raddr];
			end
		end
	end

	// never-written entries read as the reset value
	assign rd_ent = rvld_q ? rdata_q : '0;

endmodule

/* rtl/ostb_seq.sv */
// Sequencer: walks the entry memory, read-modify-write per timer, builds the result.
module ostb_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ostb_pkg::item_t    item,
	output logic               idle,
	output logic               done,
	input  logic               take,
	output ostb_pkg::res_t     res,
	output ostb_pkg::mem_req_t req,
	input  ostb_pkg::ent_t     rd_ent
);
	import ostb_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]       state_q;
	addr_t            cnt_q;
	op_t              op_q;
	logic [IDX_W-1:0] idx_q;
	cnt_t             per_q;
	logic             sel_ok_q;
	logic             rd_v_s1;
	addr_t            addr_s1;
	res_t             res_q;

	logic             item_ok;
	logic             is_tick;
	cnt_t             inc;
	ent_t             nxt;
	logic             fired;
	logic             hit;

	assign item_ok = 32'(item.idx) < NUM_TIMERS;
	assign is_tick = (op_q == OP_TICK);

	// entry update for the entry read last cycle
	always_comb begin
		nxt   = rd_ent;
		fired = 1'b0;
		inc   = (rd_ent.count == '1) ? rd_ent.count : rd_ent.count + cnt_t'(1);
		case (op_q)
			OP_TICK: begin
				if (rd_ent.running) begin
					nxt.count = inc;
					if (inc >= rd_ent.period) begin
						nxt.flag    = 1'b1;
						nxt.running = 1'b0;
						nxt.count   = '0;
						fired       = 1'b1;
					end
				end else begin
					nxt.count = '0;
				end
			end
			OP_START: begin
				if (!rd_ent.running) begin
					nxt.flag    = 1'b0;
					nxt.period  = per_q;
					nxt.running = 1'b1;
					nxt.count   = '0;
				end
			end
			OP_STOP: begin
				nxt.flag    = 1'b0;
				nxt.running = 1'b0;
				nxt.count   = '0;
			end
			default: begin
			end
		endcase
	end

	assign hit = sel_ok_q && (32'(addr_s1) == 32'(idx_q));

	// reads in the sweep always run one entry ahead of the write, so no overlap
	always_comb begin
		req.re    = (state_q == S_SWEEP);
		req.raddr = cnt_q;
		req.we    = rd_v_s1;
		req.waddr = addr_s1;
		req.wdata = nxt;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q     <= item.op;
			idx_q    <= item.idx;
			per_q    <= item.period;
			sel_ok_q <= item_ok;
		end
		addr_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
			res_q   <= '0;
		end else begin
			rd_v_s1 <= (state_q == S_SWEEP);
			if (rd_v_s1) begin
				if (hit) begin
					res_q.flag    <= nxt.flag;
					res_q.running <= nxt.running;
				end
				for (int b = 0; b < MASK_W; b++) begin
					if (is_tick && fired && (32'(addr_s1) == b)) begin
						res_q.mask[b] <= 1'b1;
					end
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q <= '0;
						if (item.op == OP_TICK) begin
							cnt_q   <= '0;
							state_q <= S_SWEEP;
						end else if (item_ok) begin
							cnt_q   <= addr_t'(item.idx);
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SWEEP: begin
					if (is_tick && (cnt_q != LAST_ADDR)) begin
						cnt_q <= cnt_q + addr_t'(1);
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FIN);
	assign res  = res_q;

endmodule

/* rtl/one_shot_timer_bank.sv */
// Top level of the one-shot timer bank: stream ports, output register, checks.
// A bank of NUM_TIMERS one-shot timers whose state (running bit, flag, 16-bit count, period)
// lives in a single-port-read memory. Each request returns one result. A tick walks every
// entry through the memory read port, one entry per cycle; start, stop and query touch one
// entry. A finished result sits in an output register, so the next request is accepted
// while it waits downstream. Out-of-range timer indexes read as zero and change nothing.
module one_shot_timer_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // op[1:0], timer_index[4:2], period_ms[20:5], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // tmo_flag[0], running[1], expired_mask[9:2], zero fill
);
	import ostb_pkg::*;

	item_t    item;
	logic     start;
	logic     idle;
	logic     done;
	logic     take;
	res_t     seq_res;
	mem_req_t mem_req;
	ent_t     rd_ent;
	res_t     out_q;
	logic     m_tvalid_q;

	assign item.op     = s_tdata[1:0];
	assign item.idx    = s_tdata[4:2];
	assign item.period = s_tdata[20:5];

	assign s_tready = idle;
	assign start    = s_tvalid && idle;
	assign take     = !m_tvalid_q || m_tready;

	ostb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.idle   (idle),
		.done   (done),
		.take   (take),
		.res    (seq_res),
		.req    (mem_req),
		.rd_ent (rd_ent)
	);

	ostb_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rd_ent (rd_ent)
	);

	always_ff @(posedge clk) begin
		if (done && take) begin
			out_q <= seq_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_q.mask, out_q.running, out_q.flag};

	// no entry is written while the sequencer waits for a request
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mem_req.we)
		else $error("entry write while idle");

	// read and write ports never hit the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("read and write to same entry");

	// all memory traffic is finished once the result is offered
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!mem_req.we && !mem_req.re))
		else $error("memory access after result ready");

endmodule
